// ===== rtl/core/ame_pkg.sv =====
// Shared constants and types for the accumulator machine executor.
`timescale 1ns / 1ps

package ame_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int MAX_STRING = 63;
  localparam int ADDR_W     = $clog2(DATA_WORDS);
  localparam int CNT_W      = $clog2(MAX_STRING + 1);
  localparam int WORD_W     = 32;

  localparam logic [7:0] OP_LOAD   = 8'h81;
  localparam logic [7:0] OP_STORE  = 8'h82;
  localparam logic [7:0] OP_ADD    = 8'h83;
  localparam logic [7:0] OP_MULT   = 8'h84;
  localparam logic [7:0] OP_STRING = 8'h85;
  localparam logic [7:0] OP_PRINT  = 8'h86;
  localparam logic [7:0] OP_HALT   = 8'h87;
  localparam logic [7:0] OP_IMM    = 8'h90;

  localparam logic [WORD_W-1:0] END_MARK = 32'h0000_005C;

  typedef enum logic [2:0] {
    K_ACC     = 3'd0,
    K_CHAR    = 3'd1,
    K_BADOP   = 3'd2,
    K_BADADDR = 3'd3,
    K_TRUNC   = 3'd4
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_t;

endpackage

// ===== rtl/core/ame_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ame_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ame_alu.sv =====
// Registered add / multiply unit for accumulator updates.
`timescale 1ns / 1ps

module ame_alu
  import ame_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  alu_op_t           op,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] result
);

  // low word of the product / sum, wrapping
  always_ff @(posedge clk) begin
    if (en) begin
      case (op)
        ALU_ADD: result <= a + b;
        ALU_MUL: result <= a * b;
        default: result <= a + b;
      endcase
    end
  end

endmodule

// ===== rtl/core/accumulator_machine_executor.sv =====
// Top level: instruction sequencer, accumulator and output register.
`timescale 1ns / 1ps

// Executes one accumulator-machine instruction (or one memory preload) per
// input item. The data memory is a single synchronous RAM of DATA_WORDS
// words with registered read; its contents are undefined until written,
// so there is no clearing pass after reset. Steps per item, from acceptance
// until in_ready returns: preload, store, immediate, halt and halted
// instructions finish on acceptance; load adds the RAM read; add and
// multiply add the RAM read, then the registered ALU, then write-back;
// print and error results add a flush, plus any stall on the output. A
// string item walks memory one word per step (one RAM read per character),
// stalling while the output cannot take a released character, then flushes
// the held character and any truncation or bad-address result. The walk
// holds each character back one step so that the last flag can be set on
// the true final result. Results leave through a one-entry output register;
// a new item is accepted while a finished result waits there.
module accumulator_machine_executor
  import ame_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     is_preload,
  input  logic [7:0]               opcode,
  input  logic [31:0]              operand,
  input  logic signed [31:0]       preload_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               kind,
  output logic signed [31:0]       value,
  output logic                     last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WB,
    S_STR,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    EX_LOAD,
    EX_ADD,
    EX_MUL
  } exec_t;

  state_t            state;
  exec_t             exec_op;
  logic [WORD_W-1:0] acc;
  logic              halted;

  // string walk
  logic [ADDR_W-1:0] str_addr;
  logic [CNT_W-1:0]  str_count;
  logic              chr_valid;
  logic [7:0]        chr_value;

  // final result pending after any held character
  logic              tail_valid;
  kind_t             tail_kind;
  logic [WORD_W-1:0] tail_value;

  // output register
  kind_t             out_kind;
  logic [WORD_W-1:0] out_value;
  logic              out_last;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              in_range;
  logic              str_ok;
  logic              is_mem_op;
  logic              str_step;
  logic              str_at_end;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              alu_en;
  alu_op_t           alu_op;
  logic [WORD_W-1:0] alu_result;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign in_range  = operand < 32'(DATA_WORDS);
  // string starts at operand + 1, which must still be inside memory
  assign str_ok    = operand < 32'(DATA_WORDS - 1);
  assign is_mem_op = (opcode == OP_LOAD) || (opcode == OP_ADD) || (opcode == OP_MULT);

  assign str_at_end = (str_addr == ADDR_W'(DATA_WORDS - 1));
  assign str_step   = (state == S_STR) && (ram_rdata != END_MARK) &&
                      (str_count != CNT_W'(MAX_STRING)) && (!chr_valid || out_free);

  // output register takes a new result: a released character during the
  // walk, or the held character / final result while flushing
  assign out_load = (str_step && chr_valid) ||
                    ((state == S_FLUSH) && (chr_valid || tail_valid) && out_free);

  assign kind  = out_kind;
  assign value = out_value;
  assign last  = out_last;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = operand[ADDR_W-1:0];
    ram_wdata = is_preload ? preload_value : acc;
    ram_re    = 1'b0;
    ram_raddr = operand[ADDR_W-1:0];
    if (in_fire) begin
      if (is_preload) begin
        ram_we = in_range;
      end else if (!halted) begin
        if (opcode == OP_STORE) begin
          ram_we = in_range;
        end else if (is_mem_op) begin
          ram_re = in_range;
        end else if (opcode == OP_STRING) begin
          ram_re    = str_ok;
          ram_raddr = operand[ADDR_W-1:0] + 1'b1;
        end
      end
    end else if (str_step && !str_at_end) begin
      ram_re    = 1'b1;
      ram_raddr = str_addr + 1'b1;
    end
  end

  assign alu_en = (state == S_EXEC) && (exec_op != EX_LOAD);
  assign alu_op = (exec_op == EX_MUL) ? ALU_MUL : ALU_ADD;

  ame_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DATA_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ame_alu u_alu (
    .clk    (clk),
    .en     (alu_en),
    .op     (alu_op),
    .a      (acc),
    .b      (ram_rdata),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      halted     <= 1'b0;
      chr_valid  <= 1'b0;
      tail_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            chr_valid <= 1'b0;
            if (is_preload) begin
              if (!in_range) begin
                tail_valid <= 1'b1;
                tail_kind  <= K_BADADDR;
                tail_value <= '0;
                state      <= S_FLUSH;
              end
            end else if (!halted) begin
              case (opcode)
                OP_LOAD, OP_ADD, OP_MULT, OP_STORE: begin
                  if (!in_range) begin
                    tail_valid <= 1'b1;
                    tail_kind  <= K_BADADDR;
                    tail_value <= '0;
                    state      <= S_FLUSH;
                  end else if (opcode != OP_STORE) begin
                    exec_op <= (opcode == OP_LOAD) ? EX_LOAD :
                               (opcode == OP_ADD)  ? EX_ADD : EX_MUL;
                    state   <= S_EXEC;
                  end
                end
                OP_STRING: begin
                  if (str_ok) begin
                    str_addr  <= operand[ADDR_W-1:0] + 1'b1;
                    str_count <= '0;
                    state     <= S_STR;
                  end else begin
                    tail_valid <= 1'b1;
                    tail_kind  <= K_BADADDR;
                    tail_value <= '0;
                    state      <= S_FLUSH;
                  end
                end
                OP_PRINT: begin
                  tail_valid <= 1'b1;
                  tail_kind  <= K_ACC;
                  tail_value <= acc;
                  state      <= S_FLUSH;
                end
                OP_IMM: begin
                  acc <= operand;
                end
                OP_HALT: begin
                  halted <= 1'b1;
                end
                default: begin
                  tail_valid <= 1'b1;
                  tail_kind  <= K_BADOP;
                  tail_value <= {24'b0, opcode};
                  state      <= S_FLUSH;
                end
              endcase
            end
          end
        end
        S_EXEC: begin
          // RAM word for the operand address is on ram_rdata
          if (exec_op == EX_LOAD) begin
            acc   <= ram_rdata;
            state <= S_IDLE;
          end else begin
            state <= S_WB;
          end
        end
        S_WB: begin
          acc   <= alu_result;
          state <= S_IDLE;
        end
        S_STR: begin
          if (ram_rdata == END_MARK) begin
            tail_valid <= 1'b0;
            state      <= S_FLUSH;
          end else if (str_count == CNT_W'(MAX_STRING)) begin
            tail_valid <= 1'b1;
            tail_kind  <= K_TRUNC;
            tail_value <= '0;
            state      <= S_FLUSH;
          end else if (str_step) begin
            // release the previous character, hold this one
            if (chr_valid) begin
              out_kind  <= K_CHAR;
              out_value <= {24'b0, chr_value};
              out_last  <= 1'b0;
            end
            chr_valid <= 1'b1;
            chr_value <= ram_rdata[7:0];
            acc       <= ram_rdata;
            str_count <= str_count + 1'b1;
            if (str_at_end) begin
              tail_valid <= 1'b1;
              tail_kind  <= K_BADADDR;
              tail_value <= '0;
              state      <= S_FLUSH;
            end else begin
              str_addr <= str_addr + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (chr_valid) begin
            if (out_free) begin
              out_kind  <= K_CHAR;
              out_value <= {24'b0, chr_value};
              out_last  <= !tail_valid;
              chr_valid <= 1'b0;
              if (!tail_valid) begin
                state <= S_IDLE;
              end
            end
          end else if (tail_valid) begin
            if (out_free) begin
              out_kind   <= tail_kind;
              out_value  <= tail_value;
              out_last   <= 1'b1;
              tail_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            // empty string: nothing to send
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/ame_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the accumulator machine executor: predicts and compares results.
module ame_result_checker
  import ame_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               is_preload,
  input  logic [7:0]         opcode,
  input  logic [31:0]        operand,
  input  logic signed [31:0] preload_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  input  logic               last,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } result_t;

  result_t           expected_results[$];
  result_t           want;
  logic [31:0]       acc_model;
  logic [31:0]       mem_model [DATA_WORDS];
  bit                halted_model;
  int                n_errors  = 0;
  int                n_pending = 0;
  int                n_checked = 0;

  assign errors  = n_errors;
  assign pending = n_pending;
  assign checked = n_checked;

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, exp_val);
    n_errors++;
  endtask

  task automatic add_result(kind_t k, logic [31:0] v);
    result_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    expected_results.push_back(r);
  endtask

  // One accepted item: update the model state and queue what it emits.
  task automatic execute_item(bit pre, logic [7:0] op, logic [31:0] opd, logic [31:0] pv);
    int          start_n;
    bit          in_range;
    logic [32:0] addr;
    int          n_chars;
    bit          done;
    logic [31:0] word;
    result_t     tail;
    start_n  = expected_results.size();
    in_range = opd < DATA_WORDS;
    if (pre) begin
      if (in_range) mem_model[opd[ADDR_W-1:0]] = pv;
      else add_result(K_BADADDR, '0);
    end else if (!halted_model) begin
      case (op)
        OP_LOAD, OP_STORE, OP_ADD, OP_MULT: begin
          if (!in_range) begin
            add_result(K_BADADDR, '0);
          end else begin
            case (op)
              OP_LOAD:  acc_model = mem_model[opd[ADDR_W-1:0]];
              OP_STORE: mem_model[opd[ADDR_W-1:0]] = acc_model;
              OP_ADD:   acc_model = acc_model + mem_model[opd[ADDR_W-1:0]];
              default:  acc_model = acc_model * mem_model[opd[ADDR_W-1:0]];
            endcase
          end
        end
        OP_STRING: begin
          addr    = {1'b0, opd} + 33'd1;
          n_chars = 0;
          done    = 1'b0;
          while (!done) begin
            if (addr >= DATA_WORDS) begin
              add_result(K_BADADDR, '0);
              done = 1'b1;
            end else begin
              word = mem_model[addr[ADDR_W-1:0]];
              if (word == END_MARK) begin
                done = 1'b1;
              end else if (n_chars >= MAX_STRING) begin
                add_result(K_TRUNC, '0);
                done = 1'b1;
              end else begin
                acc_model = word;
                add_result(K_CHAR, {24'h0, word[7:0]});
                n_chars++;
                addr = addr + 33'd1;
              end
            end
          end
        end
        OP_PRINT: add_result(K_ACC, acc_model);
        OP_IMM:   acc_model = opd;
        OP_HALT:  halted_model = 1'b1;
        default:  add_result(K_BADOP, {24'h0, op});
      endcase
    end
    if (expected_results.size() > start_n) begin
      tail      = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.push_back(tail);
    end
  endtask

  // Output side first: a result leaving at this edge belongs to an older item.
  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      acc_model    = '0;
      halted_model = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("result with nothing expected", value, '0);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (kind !== want.kind) report("kind", {29'h0, kind}, {29'h0, want.kind});
          if (value !== want.value) report("value", value, want.value);
          if (last !== want.last) report("last", {31'h0, last}, {31'h0, want.last});
        end
      end
      if (in_valid && in_ready) execute_item(is_preload, opcode, operand, preload_value);
    end
    n_pending = expected_results.size();
  end

endmodule

// ===== bench/tb_accumulator_machine_executor.sv =====
`timescale 1ns / 1ps
// Testbench top for the accumulator machine executor: stimulus, idling and verdict.
module tb_accumulator_machine_executor;
  import ame_pkg::*;

  localparam int RANDOM_ITEMS = 210;
  localparam int CALM_TAIL    = 40;       // final items sent with no idling
  localparam int CYCLE_LIMIT  = 1000000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 20;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               is_preload    = 1'b0;
  logic [7:0]         opcode        = '0;
  logic [31:0]        operand       = '0;
  logic signed [31:0] preload_value = '0;
  logic               out_ready     = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire  [2:0]         kind;
  wire signed [31:0]  value;
  wire                last;

  int errors;
  int pending;
  int checked;

  // Idling knobs: idle_pct is shared by the sender and the receiver.
  int idle_pct   = 0;
  int stall_left = 0;
  int cycles     = 0;

  // Stimulus bookkeeping only: which words are safe to read. A word written by
  // a store has unknown contents, so it is never taken as a string terminator.
  bit written   [DATA_WORDS];
  bit holds_end [DATA_WORDS];
  bit halt_sent = 1'b0;

  int n_items    = 0;
  int n_preloads = 0;
  int n_strings  = 0;
  int n_long     = 0;

  always #5 clk = ~clk;

  accumulator_machine_executor DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .is_preload    (is_preload),
    .opcode        (opcode),
    .operand       (operand),
    .preload_value (preload_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .value         (value),
    .last          (last)
  );

  ame_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .is_preload    (is_preload),
    .opcode        (opcode),
    .operand       (operand),
    .preload_value (preload_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .value         (value),
    .last          (last),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  // Receiver: stalls come in bursts whose length is drawn at random.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99, 0) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(2, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item at the falling edge, hold it until accepted.
  task automatic send_item(bit pre, logic [7:0] op, logic [31:0] opd, logic [31:0] pv);
    int gap;
    gap = 0;
    if ($urandom_range(99, 0) < idle_pct) gap = $urandom_range(3, 1);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    is_preload    <= pre;
    opcode        <= op;
    operand       <= opd;
    preload_value <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    if (pre) begin
      n_preloads++;
      if (opd < DATA_WORDS) begin
        written[opd[ADDR_W-1:0]]   = 1'b1;
        holds_end[opd[ADDR_W-1:0]] = (pv == END_MARK);
      end
    end else if (!halt_sent) begin
      if (op == OP_STRING) n_strings++;
      if (op == OP_STORE && opd < DATA_WORDS) begin
        written[opd[ADDR_W-1:0]]   = 1'b1;
        holds_end[opd[ADDR_W-1:0]] = 1'b0;
      end
      if (op == OP_HALT) halt_sent = 1'b1;
    end
  endtask

  // Opcode is a don't-care on a preload: randomize it to toggle its bits.
  task automatic preload_word(logic [31:0] addr, logic [31:0] data);
    send_item(1'b1, 8'($urandom), addr, data);
  endtask

  task automatic run_instr(logic [7:0] op, logic [31:0] opd);
    send_item(1'b0, op, opd, $urandom);
  endtask

  // True when the instruction reads only words that were written. A string
  // walk reads at most MAX_STRING + 1 words before it must stop.
  function automatic bit reads_written(logic [7:0] op, logic [31:0] opd);
    logic [32:0] addr;
    int          i;
    bit          ok;
    bit          done;
    if (op == OP_LOAD || op == OP_ADD || op == OP_MULT)
      return (opd >= DATA_WORDS) || written[opd[ADDR_W-1:0]];
    if (op != OP_STRING) return 1'b1;
    addr = {1'b0, opd} + 33'd1;
    ok   = 1'b1;
    done = 1'b0;
    for (i = 0; i <= MAX_STRING && !done; i++) begin
      if (addr >= DATA_WORDS) begin
        done = 1'b1;
      end else if (!written[addr[ADDR_W-1:0]]) begin
        ok   = 1'b0;
        done = 1'b1;
      end else if (holds_end[addr[ADDR_W-1:0]]) begin
        done = 1'b1;
      end
      addr = addr + 33'd1;
    end
    return ok;
  endfunction

  // Unsafe reads turn into out-of-range addresses, which still test the error path.
  task automatic run_instr_safe(logic [7:0] op, logic [31:0] opd);
    logic [31:0] addr;
    addr = opd;
    if (!reads_written(op, addr)) addr = $urandom | 32'h0000_0400;
    run_instr(op, addr);
  endtask

  function automatic logic [31:0] data_word();
    case ($urandom_range(5, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly printable characters; some full words, some with a backslash low
  // byte but nonzero upper bits, which must not end the string.
  function automatic logic [31:0] char_word();
    logic [31:0] w;
    case ($urandom_range(9, 0))
      0:       w = $urandom;
      1:       w = ($urandom & 32'hFFFF_FF00) | 32'h0000_015C;
      default: w = $urandom_range(126, 32);
    endcase
    if (w == END_MARK) w = w + 32'd1;
    return w;
  endfunction

  // Lay down a string in memory and walk it. to_edge leaves out the
  // terminator and packs the characters against the top of memory.
  task automatic string_run(int len, bit to_edge);
    int base;
    int i;
    if (to_edge) base = DATA_WORDS - len;
    else base = $urandom_range(DATA_WORDS - len - 2, 1);
    for (i = 0; i < len; i++) preload_word(base + i, char_word());
    if (!to_edge) preload_word(base + len, END_MARK);
    if (len >= MAX_STRING) n_long++;
    run_instr_safe(OP_STRING, base - 1);
  endtask

  task automatic random_sequence(int seq);
    int          sel;
    int          r;
    int          k;
    logic [31:0] addr;
    logic [7:0]  op;
    sel = $urandom_range(99, 0);
    if (seq == 2 || seq == 5) sel = 0;
    if (sel < 30) begin
      r = $urandom_range(39, 0);
      if (seq == 2) string_run(MAX_STRING, 1'b0);        // exactly full, no cut
      else if (seq == 5 || r == 0) string_run($urandom_range(MAX_STRING + 3, MAX_STRING + 1), 1'b0);
      else if (r < 4) string_run($urandom_range(4, 1), 1'b1);
      else string_run($urandom_range(6, 0), 1'b0);
    end else if (sel < 65) begin
      // Arithmetic chain on a freshly written word, ending with a print.
      addr = $urandom_range(DATA_WORDS - 1, 0);
      preload_word(addr, data_word());
      repeat ($urandom_range(4, 1)) begin
        k = $urandom_range(5, 0);
        case (k)
          0:       run_instr(OP_IMM, data_word());
          1:       run_instr_safe(OP_LOAD, addr);
          2:       run_instr_safe(OP_ADD, addr);
          3:       run_instr_safe(OP_MULT, addr);
          4:       run_instr(OP_STORE, $urandom_range(DATA_WORDS - 1, 0));
          default: run_instr(OP_PRINT, $urandom);
        endcase
      end
      run_instr(OP_PRINT, $urandom);
    end else if (sel < 80) begin
      k    = $urandom_range(5, 0);
      addr = $urandom_range(DATA_WORDS - 1, 0);
      case (k)
        0:       run_instr_safe(OP_LOAD, addr);
        1:       run_instr_safe(OP_ADD, addr);
        2:       run_instr_safe(OP_MULT, addr);
        3:       run_instr(OP_STORE, addr);
        4:       run_instr(OP_IMM, $urandom);
        default: run_instr(OP_PRINT, $urandom);
      endcase
    end else if ($urandom_range(1, 0)) begin
      // Noise: preload anywhere, about half of them out of range.
      preload_word($urandom_range(1, 0) ? $urandom : $urandom_range(DATA_WORDS - 1, 0),
                   $urandom);
    end else begin
      // Noise: any opcode but halt, any operand.
      op = 8'($urandom);
      if (op == OP_HALT) op = 8'h00;
      run_instr_safe(op, $urandom_range(1, 0) ? $urandom : $urandom_range(DATA_WORDS - 1, 0));
    end
  endtask

  initial begin
    int start_items;
    int seq;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: data extremes, an add that stops short of wrapping, a wrapping multiply,
    // every opcode but halt, bad addresses, unknown opcodes, empty string and a walk off memory.
    preload_word(0, 32'h7FFF_FFFF);
    preload_word(1, 32'h8000_0000);
    preload_word(DATA_WORDS - 1, 32'hFFFF_FFFF);
    run_instr(OP_LOAD, 0);
    run_instr(OP_PRINT, $urandom);
    run_instr(OP_ADD, 1);                      // sum reaches all ones without wrapping
    run_instr(OP_PRINT, $urandom);
    run_instr(OP_MULT, DATA_WORDS - 1);        // all ones squared wraps to one
    run_instr(OP_PRINT, $urandom);
    run_instr(OP_STORE, 2);
    run_instr(OP_IMM, 32'hFFFF_FFFF);
    run_instr(OP_LOAD, 2);
    run_instr(OP_PRINT, $urandom);
    run_instr(8'h00, 0);
    run_instr(8'hFF, 32'hFFFF_FFFF);
    run_instr(OP_LOAD, DATA_WORDS);
    run_instr(OP_STORE, 32'hFFFF_FFFF);
    run_instr(OP_ADD, DATA_WORDS);
    preload_word(32'hFFFF_FFFF, $urandom);
    run_instr(OP_STRING, DATA_WORDS - 1);      // first char already off memory
    run_instr(OP_STRING, 32'hFFFF_FFFF);       // address plus one overflows 32 bits
    preload_word(5, END_MARK);
    run_instr(OP_STRING, 4);                   // empty string
    string_run(3, 1'b1);                       // characters, then bad address

    // Random: mostly well-formed sequences, idling level changed every few.
    start_items = n_items;
    seq         = 0;
    while (n_items - start_items < RANDOM_ITEMS) begin
      if (seq % 6 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 45;
        endcase
      end
      if (RANDOM_ITEMS - (n_items - start_items) < CALM_TAIL) idle_pct = 0;
      random_sequence(seq);
      seq++;
    end

    // Halt, then instructions that must be ignored and preloads that still run.
    idle_pct = 0;
    run_instr(OP_HALT, $urandom);
    repeat (20) begin
      if ($urandom_range(1, 0))
        preload_word($urandom_range(1, 0) ? $urandom : $urandom_range(DATA_WORDS - 1, 0),
                     $urandom);
      else
        run_instr(8'($urandom), $urandom);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d preloads, %0d string walks (%0d at full length), halt last.",
             n_items, n_preloads, n_strings, n_long);
    $display("Compared %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ame_pkg.sv
rtl/core/ame_ram.sv
rtl/core/ame_alu.sv
rtl/core/accumulator_machine_executor.sv
bench/ame_result_checker.sv
bench/tb_accumulator_machine_executor.sv
